### hdl/rmmcs_pkg.sv
package rmmcs_pkg;
  localparam int ChanW = 8;
  localparam int NumLanes = 3;
  localparam int ProdW = 16;
  localparam logic [ChanW-1:0] ChanMax = 8'd255;
  localparam logic OpMeasure = 1'b0;
  localparam logic OpApply = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] low;
    logic [ChanW-1:0] high;
  } range_t;
endpackage

### hdl/rmmcs_lane.sv
// One color channel: running min/max tracker and a serial restoring divider.
module rmmcs_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          measure,
  input  logic                          clear,
  input  logic                          start,
  input  logic                          step,
  input  logic [rmmcs_pkg::ChanW-1:0]   sample,
  output logic [rmmcs_pkg::ChanW-1:0]   result
);
  localparam int W = rmmcs_pkg::ChanW;
  localparam int PW = rmmcs_pkg::ProdW;

  rmmcs_pkg::range_t rng;
  logic [W-1:0] lo_eff, hi_eff;

  always_comb begin
    lo_eff = clear ? rmmcs_pkg::ChanMax : rng.low;
    hi_eff = clear ? '0 : rng.high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rng.low  <= rmmcs_pkg::ChanMax;
      rng.high <= '0;
    end else if (measure) begin
      rng.low  <= (sample < lo_eff) ? sample : lo_eff;
      rng.high <= (sample > hi_eff) ? sample : hi_eff;
    end
  end

  // Division state: remainder, dividend shift register, divisor, bypass value.
  // When not bypassed, the remainder stays below the divisor, so it fits in W bits.
  logic [W-1:0]  rem;
  logic [PW-1:0] quo;
  logic [W-1:0]  span;
  logic          bypass;
  logic [W-1:0]  bypass_val;
  logic [W:0]    trial;
  logic [PW-1:0] num;

  always_comb begin
    num = PW'({8'd0, sample} - {8'd0, rng.low}) * PW'(rmmcs_pkg::ChanMax);
    trial = {rem, quo[PW-1]} - {1'b0, span};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      span <= rng.high - rng.low;
      if (rng.high <= rng.low) begin
        bypass <= 1'b1; bypass_val <= sample;
      end else if (sample <= rng.low) begin
        bypass <= 1'b1; bypass_val <= '0;
      end else if (sample >= rng.high) begin
        bypass <= 1'b1; bypass_val <= rmmcs_pkg::ChanMax;
      end else begin
        bypass <= 1'b0; bypass_val <= '0;
      end
    end else if (step) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[PW-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[PW-1]};
        quo <= {quo[PW-2:0], 1'b0};
      end
    end
  end

  // Quotient is below 255 when not bypassed, so the low byte suffices.
  assign result = bypass ? bypass_val : quo[W-1:0];
endmodule

### hdl/rmmcs_merge.sv
// Collects the three lane results into the output word register.
module rmmcs_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        take,
  input  logic [rmmcs_pkg::ChanW-1:0] r,
  input  logic [rmmcs_pkg::ChanW-1:0] g,
  input  logic [rmmcs_pkg::ChanW-1:0] b,
  output logic                        valid,
  output logic [3*rmmcs_pkg::ChanW-1:0] word
);
  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (load) valid <= 1'b1;
    else if (take) valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (load) word <= {b, g, r};
  end
endmodule

### hdl/rgb_min_max_contrast_stretch.sv
// Flow: a measure word updates the range registers when it is accepted; an apply
// word's pixel is offered after the 16 divider steps, then the merge register.
// Throughput: one measure word per cycle while no division runs and no pixel waits;
// a new apply word waits until the previous one has passed the bit-serial restoring
// divider in each of the three channel lanes and its pixel has been taken.
// Reset: synchronous active-high rst sets every minimum to 255 and every
// maximum to 0, and empties the output register.
module rgb_min_max_contrast_stretch (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // red_in, green_in, blue_in
  input  logic [1:0]  s_tuser,  // operation, first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // red_out, green_out, blue_out
);
  localparam int W = rmmcs_pkg::ChanW;
  localparam int Steps = rmmcs_pkg::ProdW;

  logic acc, is_apply, measure, start, step, done, busy, out_valid;
  logic [4:0] cnt;
  logic [W-1:0] q_r, q_g, q_b;

  // Input accepted only while no division runs and the output register is free.
  assign s_tready = !busy && !out_valid;
  assign acc = s_tvalid && s_tready;
  assign is_apply = s_tuser[0] == rmmcs_pkg::OpApply;
  assign measure = acc && !is_apply;
  assign start = acc && is_apply;
  assign step = busy && cnt != 5'(Steps);
  assign done = busy && cnt == 5'(Steps);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (step) begin
      cnt <= cnt + 5'd1;
    end
  end

  rmmcs_lane u_red (.clk, .rst, .measure, .clear(s_tuser[1]), .start, .step,
    .sample(s_tdata[7:0]), .result(q_r));
  rmmcs_lane u_grn (.clk, .rst, .measure, .clear(s_tuser[1]), .start, .step,
    .sample(s_tdata[15:8]), .result(q_g));
  rmmcs_lane u_blu (.clk, .rst, .measure, .clear(s_tuser[1]), .start, .step,
    .sample(s_tdata[23:16]), .result(q_b));

  rmmcs_merge u_merge (.clk, .rst, .load(done), .take(m_tready), .r(q_r),
    .g(q_g), .b(q_b), .valid(out_valid), .word(m_tdata));

  assign m_tvalid = out_valid;

  // Note: s_tdata holds the sample stable during division only in that the
  // lane registered num at start; the divider never reads sample after start.

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("accepted while dividing");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    done |=> m_tvalid) else $error("result lost");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider did not start");
endmodule
